FILE: sv/kmp_pkg.sv
package kmp_pkg;

	// widths of the stream payloads
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned START_W = 32;
	localparam int unsigned MLEN_W  = 7;
	localparam int unsigned S_DATA_W = 8;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 48;

	// item kinds carried in s_tuser[0]
	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LOOKUP,
		ST_COMPARE,
		ST_TAIL,
		ST_TAIL_USE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the accepted beat, apply restart
		logic setup;     // load the working length
		logic lookup;    // address the memories at the working length
		logic step;      // compare and advance or fall back
		logic tail;      // address the last prefix entry
		logic tail_use;  // fall back after a full match
		logic commit;    // write back state and the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_text;
		logic full;
		logic empty;
		logic step_done;
		logic hit;
		logic out_free;
	} status_t;

endpackage

FILE: sv/kmp_ctrl.sv
module kmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  kmp_pkg::status_t  status,
	output kmp_pkg::cmd_t     cmd
);

	kmp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kmp_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = kmp_pkg::ST_SETUP;
			end
			kmp_pkg::ST_SETUP: begin
				// dropped bytes, the first pattern byte and an empty pattern need no search
				if (status.empty || (!status.is_text && status.full)) begin
					state_d = kmp_pkg::ST_FINISH;
				end else begin
					state_d = kmp_pkg::ST_LOOKUP;
				end
			end
			kmp_pkg::ST_LOOKUP:  state_d = kmp_pkg::ST_COMPARE;
			kmp_pkg::ST_COMPARE: begin
				if (!status.step_done) begin
					state_d = kmp_pkg::ST_LOOKUP;
				end else if (status.hit) begin
					state_d = kmp_pkg::ST_TAIL;
				end else begin
					state_d = kmp_pkg::ST_FINISH;
				end
			end
			kmp_pkg::ST_TAIL:     state_d = kmp_pkg::ST_TAIL_USE;
			kmp_pkg::ST_TAIL_USE: state_d = kmp_pkg::ST_FINISH;
			kmp_pkg::ST_FINISH: begin
				if (status.out_free) state_d = kmp_pkg::ST_IDLE;
			end
			default: state_d = kmp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			kmp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			kmp_pkg::ST_SETUP:    cmd.setup    = 1'b1;
			kmp_pkg::ST_LOOKUP:   cmd.lookup   = 1'b1;
			kmp_pkg::ST_COMPARE:  cmd.step     = 1'b1;
			kmp_pkg::ST_TAIL:     cmd.tail     = 1'b1;
			kmp_pkg::ST_TAIL_USE: cmd.tail_use = 1'b1;
			kmp_pkg::ST_FINISH:   cmd.commit   = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: sv/kmp_datapath.sv
module kmp_datapath #(
	parameter int unsigned MAX_PATTERN   = 64,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [kmp_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [kmp_pkg::S_USER_W-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kmp_pkg::M_DATA_W-1:0]    m_tdata,
	input  kmp_pkg::cmd_t                   cmd,
	output kmp_pkg::status_t                status
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W = $clog2(MAX_PATTERN);

	logic [kmp_pkg::SYM_W-1:0] store_mem  [MAX_PATTERN];
	logic [IDX_W-1:0]          prefix_mem [MAX_PATTERN];
	logic [kmp_pkg::SYM_W-1:0] store_rd_q;
	logic [IDX_W-1:0]          prefix_rd_q;
	logic [IDX_W-1:0]          prefix_raddr;

	logic                      kind_q;
	logic [kmp_pkg::SYM_W-1:0] sym_q;
	logic [LEN_W-1:0]          plen_q;
	logic [IDX_W-1:0]          build_q;
	logic [LEN_W-1:0]          ml_q;
	logic [POSITION_BITS-1:0]  pos_q;
	logic [LEN_W-1:0]          j_q;
	logic                      found_q;
	logic [POSITION_BITS-1:0]  start_q;
	logic                      out_valid_q;
	logic [kmp_pkg::M_DATA_W-1:0] out_data_q;

	logic eq, j_zero, full, pat_write;
	logic [POSITION_BITS-1:0] start_pos;
	logic [63:0]              start_wide;
	logic [LEN_W-1:0]         res_len;

	assign eq        = store_rd_q == sym_q;
	assign j_zero    = j_q == '0;
	assign full      = plen_q >= LEN_W'(MAX_PATTERN);
	assign pat_write = cmd.commit && (kind_q == kmp_pkg::KIND_PATTERN) && !full;
	assign start_pos = pos_q - POSITION_BITS'(plen_q - LEN_W'(1));
	assign start_wide = 64'(start_q);
	assign res_len   = (kind_q == kmp_pkg::KIND_TEXT) ? j_q : ml_q;

	assign prefix_raddr = cmd.tail ? IDX_W'(plen_q - LEN_W'(1)) : IDX_W'(j_q - LEN_W'(1));

	assign status.is_text   = kind_q == kmp_pkg::KIND_TEXT;
	assign status.full      = full;
	assign status.empty     = plen_q == '0;
	assign status.step_done = j_zero || eq;
	assign status.hit       = (kind_q == kmp_pkg::KIND_TEXT) && eq
		&& ((j_q + LEN_W'(1)) == plen_q);
	assign status.out_free  = !out_valid_q || m_tready;

	// pattern store and prefix table, one write and one registered read each
	always_ff @(posedge clk) begin
		if (pat_write) begin
			store_mem[IDX_W'(plen_q)]  <= sym_q;
			prefix_mem[IDX_W'(plen_q)] <= IDX_W'(j_q);
		end
		if (cmd.lookup) begin
			store_rd_q <= store_mem[IDX_W'(j_q)];
		end
		if (cmd.lookup || cmd.tail) begin
			prefix_rd_q <= prefix_mem[prefix_raddr];
		end
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= s_tuser[0];
			sym_q  <= s_tdata[kmp_pkg::SYM_W-1:0];
		end
		if (cmd.setup) begin
			found_q <= 1'b0;
			start_q <= '0;
			if (plen_q == '0) begin
				j_q <= '0;
			end else if (kind_q == kmp_pkg::KIND_PATTERN) begin
				j_q <= LEN_W'(build_q);
			end else begin
				j_q <= (ml_q >= plen_q) ? '0 : ml_q;
			end
		end
		if (cmd.step) begin
			if (!j_zero && !eq) begin
				j_q <= LEN_W'(prefix_rd_q);
			end else if (eq) begin
				j_q <= j_q + LEN_W'(1);
			end
			if (status.hit) begin
				found_q <= 1'b1;
				start_q <= start_pos;
			end
		end
		if (cmd.tail_use) begin
			j_q <= LEN_W'(prefix_rd_q);
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			build_q <= '0;
			ml_q    <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.load && s_tuser[1]) begin
				ml_q <= '0;
				if (s_tuser[0] == kmp_pkg::KIND_PATTERN) begin
					plen_q  <= '0;
					build_q <= '0;
				end else begin
					pos_q <= '0;
				end
			end
			if (pat_write) begin
				plen_q  <= plen_q + LEN_W'(1);
				build_q <= IDX_W'(j_q);
			end
			if (cmd.commit && (kind_q == kmp_pkg::KIND_TEXT)) begin
				ml_q  <= j_q;
				pos_q <= pos_q + POSITION_BITS'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {
				7'b0,
				(kind_q == kmp_pkg::KIND_PATTERN) && full,
				kmp_pkg::MLEN_W'(res_len),
				start_wide[kmp_pkg::START_W-1:0],
				found_q
			};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: sv/kmp_stream_matcher_unit.sv
// streaming knuth-morris-pratt matcher: a beat with kind 0 appends its byte to the stored
// pattern (up to MAX_PATTERN bytes, later ones are dropped and flagged), building the
// prefix-function entry as it goes; a beat with kind 1 searches one text byte; first
// restarts the pattern or the text position; every input beat gives exactly one output
// beat; one item is in flight at a time: from acceptance it goes through setup, then
// through one or more compare steps of the prefix fallback chain (each step is one
// registered read of the pattern store and prefix table, then a compare), then, when a
// text byte completes a match, through a read of the last prefix entry and the fallback
// through it, and then to write back into the output register; the first pattern byte,
// a dropped byte and text against an empty pattern go from setup straight to write back;
// the next beat can be taken in the cycle after the result is written; the output register
// holds a result until the downstream side takes it, and while it is still full the next
// result waits in write back; the memories hold no reset: only written entries are read
module kmp_stream_matcher_unit #(
	parameter int unsigned MAX_PATTERN   = 64,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [0] kind, [1] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [0] found, [32:1] match_start,
	                               // [39:33] matched_length, [40] pattern_dropped,
	                               // [47:41] zero
);

	kmp_pkg::cmd_t    cmd;
	kmp_pkg::status_t status;

	// sequencer: walks each item through setup, fallback steps and write back
	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// pattern memories, lengths, text position and the output register
	kmp_datapath #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

	// after a beat is taken, s_tready drops: the item must go through setup
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input beat accepted while an item is in flight");

	// a result is only written when the output register is free or being emptied
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("result overwrote an untaken output beat");

	// a full match is always followed by the fallback through the last prefix entry
	a_hit_tail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.hit |=> cmd.tail ##1 cmd.tail_use)
		else $error("full match not followed by prefix fallback");

endmodule
